// ===== hw/rtl/hkr_pkg.sv =====
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants of the keyboard report builder
// Holds the action codes, the modifier virtual-key decode and the structs
// that run between the top level and the key slot cells.
// ----------------------------------------------------------------------------
package hkr_pkg;

	localparam int KEY_SLOTS_DEF  = 6;
	localparam int KEY_SLOTS_MAX  = 16;
	localparam int REPORTED_SLOTS = 6;

	typedef logic [7:0] usage_t;
	typedef logic [7:0] vkey_t;
	typedef logic [7:0] mod_mask_t;

	typedef enum logic {
		ACT_KEY_EVENT   = 1'b0,
		ACT_RELEASE_ALL = 1'b1
	} action_t;

	// Modifier virtual keys
	localparam vkey_t MODKEY_SHIFT  = 8'h10;
	localparam vkey_t MODKEY_CTRL   = 8'h11;
	localparam vkey_t MODKEY_ALT    = 8'h12;
	localparam vkey_t MODKEY_LWIN   = 8'h5B;
	localparam vkey_t MODKEY_RWIN   = 8'h5C;
	localparam vkey_t MODKEY_LSHIFT = 8'hA0;
	localparam vkey_t MODKEY_RSHIFT = 8'hA1;
	localparam vkey_t MODKEY_LCTRL  = 8'hA2;
	localparam vkey_t MODKEY_RCTRL  = 8'hA3;
	localparam vkey_t MODKEY_LALT   = 8'hA4;
	localparam vkey_t MODKEY_RALT   = 8'hA5;

	// Modifier byte bits
	localparam mod_mask_t MOD_LCTRL  = 8'h01;
	localparam mod_mask_t MOD_LSHIFT = 8'h02;
	localparam mod_mask_t MOD_LALT   = 8'h04;
	localparam mod_mask_t MOD_LGUI   = 8'h08;
	localparam mod_mask_t MOD_RCTRL  = 8'h10;
	localparam mod_mask_t MOD_RSHIFT = 8'h20;
	localparam mod_mask_t MOD_RALT   = 8'h40;
	localparam mod_mask_t MOD_RGUI   = 8'h80;
	localparam mod_mask_t MOD_NONE   = 8'h00;

	localparam usage_t USAGE_EMPTY = 8'h00;

	// Update command broadcast to every slot cell
	typedef struct packed {
		logic   clear;    // release all
		logic   press;    // non-modifier press, usage nonzero
		logic   release_; // non-modifier release, usage nonzero
		usage_t usage;
	} slot_cmd_t;

	// Carries passed from one cell to the next
	typedef struct packed {
		logic matched; // an earlier slot holds the usage
		logic empty;   // an earlier slot is empty
	} slot_chain_t;

	function automatic mod_mask_t modifier_mask(input vkey_t vk);
		mod_mask_t m;
		unique case (vk)
			MODKEY_LCTRL:               m = MOD_LCTRL;
			MODKEY_LSHIFT:              m = MOD_LSHIFT;
			MODKEY_LALT:                m = MOD_LALT;
			MODKEY_LWIN:                m = MOD_LGUI;
			MODKEY_CTRL, MODKEY_RCTRL:  m = MOD_RCTRL;
			MODKEY_SHIFT, MODKEY_RSHIFT: m = MOD_RSHIFT;
			MODKEY_ALT, MODKEY_RALT:    m = MOD_RALT;
			MODKEY_RWIN:                m = MOD_RGUI;
			default:                    m = MOD_NONE;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/hkr_if.sv =====
// ----------------------------------------------------------------------------
// hkr_if: channel interfaces of the keyboard report builder
// Key event channel and report channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkr_in_if;
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [7:0]           virtual_key;
	logic                 key_up;
	logic [7:0]           usage_code;

	modport source (output valid, action, virtual_key, key_up, usage_code, input ready);
	modport sink   (input valid, action, virtual_key, key_up, usage_code, output ready);
endinterface

interface hkr_out_if;
	logic                 valid;
	logic                 ready;
	logic [7:0]           modifier_byte;
	logic [7:0]           slot0;
	logic [7:0]           slot1;
	logic [7:0]           slot2;
	logic [7:0]           slot3;
	logic [7:0]           slot4;
	logic [7:0]           slot5;
	logic                 overflow;

	modport source (output valid, modifier_byte, slot0, slot1, slot2, slot3, slot4, slot5,
		overflow, input ready);
	modport sink   (input valid, modifier_byte, slot0, slot1, slot2, slot3, slot4, slot5,
		overflow, output ready);
endinterface

// ===== hw/rtl/hkr_slot_cell.sv =====
// ----------------------------------------------------------------------------
// hkr_slot_cell: one key slot of the report
// Holds one usage, compares it with the event and passes the match and
// empty carries on to the next cell in the row.
// ----------------------------------------------------------------------------
module hkr_slot_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  hkr_pkg::slot_cmd_t  cmd,
	input  logic                held,
	input  hkr_pkg::slot_chain_t chain_in,
	output hkr_pkg::slot_chain_t chain_out,
	output hkr_pkg::usage_t     slot
);
	import hkr_pkg::*;

	usage_t slot_q;
	logic   hit;
	logic   is_empty;

	assign hit      = (slot_q == cmd.usage);
	assign is_empty = (slot_q == USAGE_EMPTY);

	assign chain_out.matched = chain_in.matched | hit;
	assign chain_out.empty   = chain_in.empty | is_empty;
	assign slot              = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= USAGE_EMPTY;
		end else if (en) begin
			if (cmd.clear) begin
				slot_q <= USAGE_EMPTY;
			end else if (cmd.release_ && hit && !chain_in.matched) begin
				// first slot holding the usage
				slot_q <= USAGE_EMPTY;
			end else if (cmd.press && !held && is_empty && !chain_in.empty) begin
				// first empty slot takes the new key
				slot_q <= cmd.usage;
			end
		end
	end

endmodule

// ===== hw/rtl/hid_keyboard_report_builder.sv =====
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder: boot keyboard report with key rollover
// Keeps a modifier byte and a row of key slot cells, updated per key event.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one key event or a release-all action per item. For each
//   accepted item report_out delivers one item: the modifier byte, the first
//   six key slots and an overflow flag for a press that found no empty slot.
//   The update is done in the cycle of acceptance; the report appears on the
//   next cycle. One item per cycle is sustained as long as the receiver
//   takes each report: the match and empty carries ripple through all
//   KEY_SLOTS cells combinationally, within the cycle of acceptance.
//   Reset clears the modifiers, empties every slot and drops any pending
//   report. While the receiver stalls, the report holds and key_in stays
//   not ready; a new item is taken in the same cycle the report is taken.
//   KEY_SLOTS sets the number of cells (1 to 16); slot fields past it read
//   zero, and slots past the sixth are kept but not reported.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder #(
	parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	hkr_in_if.sink   key_in,
	hkr_out_if.source report_out
);
	import hkr_pkg::*;

	logic        accept;
	logic        out_valid_q;
	logic        overflow_q;
	mod_mask_t   modifier_q;
	mod_mask_t   mask;
	logic        is_event;
	slot_cmd_t   cmd;
	logic        held;
	logic        new_overflow;
	slot_chain_t chain [KEY_SLOTS+1];
	usage_t      slots [KEY_SLOTS];
	usage_t      report [REPORTED_SLOTS];

	assign key_in.ready = !out_valid_q || report_out.ready;
	assign accept       = key_in.valid && key_in.ready;

	assign mask     = modifier_mask(key_in.virtual_key);
	assign is_event = (action_t'(key_in.action) == ACT_KEY_EVENT) && (mask == MOD_NONE)
		&& (key_in.usage_code != USAGE_EMPTY);

	always_comb begin
		cmd.clear    = (action_t'(key_in.action) == ACT_RELEASE_ALL);
		cmd.press    = is_event && !key_in.key_up;
		cmd.release_ = is_event && key_in.key_up;
		cmd.usage    = key_in.usage_code;
	end

	assign chain[0] = '{matched: 1'b0, empty: 1'b0};

	genvar g;
	generate
		for (g = 0; g < KEY_SLOTS; g++) begin : g_cell
			hkr_slot_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (accept),
				.cmd       (cmd),
				.held      (held),
				.chain_in  (chain[g]),
				.chain_out (chain[g+1]),
				.slot      (slots[g])
			);
		end
		for (g = 0; g < REPORTED_SLOTS; g++) begin : g_report
			if (g < KEY_SLOTS) begin : g_live
				assign report[g] = slots[g];
			end else begin : g_zero
				assign report[g] = USAGE_EMPTY;
			end
		end
	endgenerate

	assign held         = chain[KEY_SLOTS].matched;
	assign new_overflow = cmd.press && !held && !chain[KEY_SLOTS].empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modifier_q  <= MOD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (report_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (cmd.clear) begin
					modifier_q <= MOD_NONE;
				end else if (key_in.key_up) begin
					modifier_q <= modifier_q & ~mask;
				end else begin
					modifier_q <= modifier_q | mask;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			overflow_q <= new_overflow;
		end
	end

	// state only moves on acceptance, so the report reads the state directly
	assign report_out.valid         = out_valid_q;
	assign report_out.modifier_byte = modifier_q;
	assign report_out.slot0         = report[0];
	assign report_out.slot1         = report[1];
	assign report_out.slot2         = report[2];
	assign report_out.slot3         = report[3];
	assign report_out.slot4         = report[4];
	assign report_out.slot5         = report[5];
	assign report_out.overflow      = overflow_q;

endmodule
